### design/evfp_pkg.sv
`default_nettype none

package evfp_pkg;

    localparam int LENGTH_BITS_DEFAULT = 14;
    localparam int FIFO_DEPTH_DEFAULT  = 4;

    localparam int LEN_W    = 14;
    localparam int MAXP_W   = 14;
    localparam int TAGT_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int POS_W    = 5;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VLAN_TAG_TYPE = 2'd1;

    localparam logic [MAXP_W-1:0] MAX_PAYLOAD_RESET   = 14'd1500;
    localparam logic [TAGT_W-1:0] VLAN_TAG_TYPE_RESET = 16'h8100;

    localparam logic [POS_W-1:0] DEST_END      = 5'd6;
    localparam logic [POS_W-1:0] SRC_END       = 5'd12;
    localparam logic [POS_W-1:0] TYPE_LAST     = 5'd13;
    localparam logic [POS_W-1:0] PLAIN_HEADER  = 5'd14;
    localparam logic [POS_W-1:0] TAG_END       = 5'd16;
    localparam logic [POS_W-1:0] TAGGED_HEADER = 5'd18;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_OVER  = 2'd2
    } status_t;

    typedef struct packed {
        logic            kind;
        logic [7:0]      payload_byte;
        logic [47:0]     dest_addr;
        logic [47:0]     source_addr;
        logic            tagged_res;
        logic [11:0]     vlan_number;
        logic [15:0]     type_field;
        logic [LEN_W-1:0] payload_length;
        status_t         status;
        logic            last;
    } res_t;

    typedef struct packed {
        logic [1:0] n;
        res_t       first;
        res_t       second;
    } push_t;

endpackage

`default_nettype wire

### design/evfp_in_if.sv
`default_nettype none

interface evfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       end_of_frame;

    modport source (output valid, output byte_value, output end_of_frame, input ready);
    modport sink   (input valid, input byte_value, input end_of_frame, output ready);
endinterface

`default_nettype wire

### design/evfp_out_if.sv
`default_nettype none

interface evfp_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  payload_byte;
    logic [47:0] dest_addr;
    logic [47:0] source_addr;
    logic        tagged_res;
    logic [11:0] vlan_number;
    logic [15:0] type_field;
    logic [13:0] payload_length;
    logic [1:0]  status;
    logic        last;

    modport source (
        output valid, output kind, output payload_byte, output dest_addr,
        output source_addr, output tagged_res, output vlan_number, output type_field,
        output payload_length, output status, output last, input ready
    );
    modport sink (
        input valid, input kind, input payload_byte, input dest_addr,
        input source_addr, input tagged_res, input vlan_number, input type_field,
        input payload_length, input status, input last, output ready
    );
endinterface

`default_nettype wire

### design/ethernet_vlan_frame_parser_top.sv
// Ethernet II header parser with 802.1Q VLAN tag detection.
// Channel bytes: one frame byte per transfer, end_of_frame set on the final byte.
// Channel results: one item per transfer, either a payload byte (kind 0) or the
// end-of-frame summary (kind 1) with addresses, VLAN id, ethertype, payload
// length and status. The final byte of a frame may yield both, payload first.
// Configuration: cfg_we with cfg_index 0 writes max_payload, index 1 writes
// vlan_tag_type; write only while no frame byte is in flight.
// Throughput: one byte per cycle while results are taken. A byte passes an
// input register, then the parse logic writes its results into a small
// result queue, from which a result can be taken once written. The queue drains
// one result per cycle while ready is high; a frame's extra summary is absorbed
// during the next frame's header bytes, which produce no result.
// Stall: when the receiver holds ready low the queue fills and bytes.ready
// drops once fewer than two free entries remain; no result is lost.
// Reset: registers return to max_payload 1500 and tag type 0x8100, the frame
// state clears and the result queue empties.
`default_nettype none

module ethernet_vlan_frame_parser_top #(
    parameter int LENGTH_BITS = evfp_pkg::LENGTH_BITS_DEFAULT,
    parameter int FIFO_DEPTH  = evfp_pkg::FIFO_DEPTH_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    evfp_in_if.sink                               bytes,
    evfp_out_if.source                            results,
    input  wire logic                             cfg_we,
    input  wire logic [evfp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [evfp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import evfp_pkg::*;

    logic [MAXP_W-1:0] max_payload_reg;
    logic [TAGT_W-1:0] vlan_tag_type_reg;
    logic              room;
    push_t             push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg   <= MAX_PAYLOAD_RESET;
            vlan_tag_type_reg <= VLAN_TAG_TYPE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_PAYLOAD:   max_payload_reg   <= cfg_data[MAXP_W-1:0];
                REG_VLAN_TAG_TYPE: vlan_tag_type_reg <= cfg_data[TAGT_W-1:0];
                default:           ;
            endcase
        end
    end

    evfp_parse #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parse (
        .clk           (clk),
        .rst_n         (rst_n),
        .bytes         (bytes),
        .room          (room),
        .max_payload   (max_payload_reg),
        .vlan_tag_type (vlan_tag_type_reg),
        .push          (push)
    );

    evfp_result_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .room    (room),
        .results (results)
    );

endmodule

`default_nettype wire

### design/evfp_parse.sv
`default_nettype none

module evfp_parse #(
    parameter int LENGTH_BITS = 14
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    evfp_in_if.sink                           bytes,
    input  wire logic                         room,
    input  wire logic [evfp_pkg::MAXP_W-1:0]  max_payload,
    input  wire logic [evfp_pkg::TAGT_W-1:0]  vlan_tag_type,
    output evfp_pkg::push_t                   push
);
    import evfp_pkg::*;

    localparam int CMP_W = (LENGTH_BITS > LEN_W) ? LENGTH_BITS : LEN_W;
    localparam logic [LENGTH_BITS-1:0] COUNT_TOP = '1;

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_eof_reg;
    logic       advance;

    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [47:0]            dest_reg, dest_next;
    logic [47:0]            src_reg, src_next;
    logic [15:0]            ftw_reg, ftw_next;
    logic                   tag_reg, tag_next;
    logic [11:0]            tag_id_reg, tag_id_next;
    logic [15:0]            type_reg, type_next;
    logic [LENGTH_BITS-1:0] cnt_reg, cnt_next;
    logic                   ovf_reg, ovf_next;

    logic [POS_W-1:0] hdr_len;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] cnt_ext_next;
    logic [CMP_W-1:0] max_ext;
    logic             pay_hit;
    logic             complete;
    res_t             pay_res;
    res_t             sum_res;

    assign advance     = s1_valid_reg && room;
    assign bytes.ready = !s1_valid_reg || room;

    assign hdr_len = tag_reg ? TAGGED_HEADER : PLAIN_HEADER;
    assign cnt_ext = CMP_W'(cnt_reg);
    assign max_ext = CMP_W'(max_payload);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (bytes.ready)
        begin
            s1_valid_reg <= bytes.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bytes.valid && bytes.ready)
        begin
            s1_byte_reg <= bytes.byte_value;
            s1_eof_reg  <= bytes.end_of_frame;
        end
    end

    always_comb
    begin
        pos_next     = pos_reg;
        dest_next    = dest_reg;
        src_next     = src_reg;
        ftw_next     = ftw_reg;
        tag_next     = tag_reg;
        tag_id_next  = tag_id_reg;
        type_next    = type_reg;
        cnt_next     = cnt_reg;
        ovf_next     = ovf_reg;
        pay_hit      = 1'b0;
        complete     = 1'b0;
        cnt_ext_next = '0;
        pay_res      = '0;
        sum_res      = '0;
        push         = '0;
        if (advance)
        begin
            if (pos_reg < hdr_len)
            begin
                if (pos_reg < DEST_END)
                begin
                    dest_next = {dest_reg[39:0], s1_byte_reg};
                end
                else if (pos_reg < SRC_END)
                begin
                    src_next = {src_reg[39:0], s1_byte_reg};
                end
                else if (pos_reg < PLAIN_HEADER)
                begin
                    ftw_next = {ftw_reg[7:0], s1_byte_reg};
                    if (pos_reg == TYPE_LAST)
                    begin
                        tag_next = ({ftw_reg[7:0], s1_byte_reg} == vlan_tag_type);
                    end
                end
                else if (pos_reg < TAG_END)
                begin
                    tag_id_next = {tag_id_reg[3:0], s1_byte_reg};
                end
                else
                begin
                    type_next = {type_reg[7:0], s1_byte_reg};
                end
                pos_next = pos_reg + POS_W'(1);
            end
            else
            begin
                if (cnt_ext >= max_ext)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    pay_hit = 1'b1;
                end
                if (cnt_reg != COUNT_TOP)
                begin
                    cnt_next = cnt_reg + LENGTH_BITS'(1);
                end
            end

            pay_res.kind         = KIND_PAYLOAD;
            pay_res.payload_byte = s1_byte_reg;
            pay_res.status       = ST_OK;
            pay_res.last         = !s1_eof_reg;

            complete     = pos_next >= (tag_next ? TAGGED_HEADER : PLAIN_HEADER);
            cnt_ext_next = CMP_W'(cnt_next);
            sum_res.kind = KIND_SUMMARY;
            sum_res.last = 1'b1;
            if (complete)
            begin
                sum_res.dest_addr      = dest_next;
                sum_res.source_addr    = src_next;
                sum_res.tagged_res     = tag_next;
                sum_res.vlan_number    = tag_next ? tag_id_next : 12'd0;
                sum_res.type_field     = tag_next ? type_next : ftw_next;
                sum_res.payload_length = cnt_ext_next[LEN_W-1:0];
                sum_res.status         = ovf_next ? ST_OVER : ST_OK;
            end
            else
            begin
                sum_res.status = ST_SHORT;
            end

            if (pay_hit)
            begin
                push.first  = pay_res;
                push.second = sum_res;
                push.n      = s1_eof_reg ? 2'd2 : 2'd1;
            end
            else if (s1_eof_reg)
            begin
                push.first = sum_res;
                push.n     = 2'd1;
            end

            if (s1_eof_reg)
            begin
                pos_next    = '0;
                dest_next   = '0;
                src_next    = '0;
                ftw_next    = '0;
                tag_next    = 1'b0;
                tag_id_next = '0;
                type_next   = '0;
                cnt_next    = '0;
                ovf_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            dest_reg   <= '0;
            src_reg    <= '0;
            ftw_reg    <= '0;
            tag_reg    <= 1'b0;
            tag_id_reg <= '0;
            type_reg   <= '0;
            cnt_reg    <= '0;
            ovf_reg    <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            dest_reg   <= dest_next;
            src_reg    <= src_next;
            ftw_reg    <= ftw_next;
            tag_reg    <= tag_next;
            tag_id_reg <= tag_id_next;
            type_reg   <= type_next;
            cnt_reg    <= cnt_next;
            ovf_reg    <= ovf_next;
        end
    end

endmodule

`default_nettype wire

### design/evfp_result_fifo.sv
`default_nettype none

module evfp_result_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire evfp_pkg::push_t push,
    output logic             room,
    evfp_out_if.source       results
);
    import evfp_pkg::*;

    localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    res_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_1;
    logic [PTR_W-1:0] wr_ptr_2;
    logic             pop;
    res_t             head;

    assign room = count_reg <= CNT_W'(DEPTH - 2);
    assign pop  = results.valid && results.ready;
    assign head = mem_reg[rd_ptr_reg];

    assign wr_ptr_1 = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
    assign wr_ptr_2 = (wr_ptr_1 == PTR_LAST) ? '0 : wr_ptr_1 + PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        case (push.n)
            2'd1:    wr_ptr_next = wr_ptr_1;
            2'd2:    wr_ptr_next = wr_ptr_2;
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W'(push.n) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.n == 2'd2)
        begin
            mem_reg[wr_ptr_1] <= push.second;
        end
    end

    assign results.valid          = count_reg != '0;
    assign results.kind           = head.kind;
    assign results.payload_byte   = head.payload_byte;
    assign results.dest_addr      = head.dest_addr;
    assign results.source_addr    = head.source_addr;
    assign results.tagged_res     = head.tagged_res;
    assign results.vlan_number    = head.vlan_number;
    assign results.type_field     = head.type_field;
    assign results.payload_length = head.payload_length;
    assign results.status         = head.status;
    assign results.last           = head.last;

endmodule

`default_nettype wire

### design/evfp_checker.sv
`default_nettype none

module evfp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        out_kind,
    input wire logic        out_last,
    input wire logic [1:0]  out_status,
    input wire logic [47:0] out_dest,
    input wire logic [13:0] out_length,
    input wire logic [15:0] out_type
);
    import evfp_pkg::*;

    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == KIND_SUMMARY |-> out_last)
        else $error("summary item without last");

    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == KIND_PAYLOAD |-> out_status == ST_OK && out_dest == 48'd0)
        else $error("payload item carries summary fields");

    a_short_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == KIND_SUMMARY && out_status == ST_SHORT
        |-> out_length == 14'd0 && out_type == 16'd0 && out_dest == 48'd0)
        else $error("short frame summary carries header fields");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_status)
        && $stable(out_length))
        else $error("result changed while stalled");

endmodule

bind ethernet_vlan_frame_parser_top evfp_checker u_evfp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .out_kind   (results.kind),
    .out_last   (results.last),
    .out_status (results.status),
    .out_dest   (results.dest_addr),
    .out_length (results.payload_length),
    .out_type   (results.type_field)
);

`default_nettype wire

### tb/tb_ethernet_vlan_frame_parser_top.sv
module tb_ethernet_vlan_frame_parser_top;
    import evfp_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SEG_BYTES   = 90;
    localparam int TOP_FRAME_PAYLOAD = 60;

    class frame_scoreboard;
        logic [MAXP_W-1:0] max_payload;
        logic [TAGT_W-1:0] tag_type;
        logic [POS_W-1:0]  hdr_pos;
        logic [47:0]       dest_acc;
        logic [47:0]       src_acc;
        logic [15:0]       type_word;
        logic [15:0]       eth_type;
        logic              tag_flag;
        logic [11:0]       vid;
        int unsigned       pay_count;
        logic              over;
        res_t              pending_results[$];
        int                errors;
        int                bytes_seen;
        int                payload_seen;
        int                summaries_seen;
        int                tagged_seen;
        int                short_seen;
        int                over_seen;

        function new();
            max_payload    = MAX_PAYLOAD_RESET;
            tag_type       = VLAN_TAG_TYPE_RESET;
            errors         = 0;
            bytes_seen     = 0;
            payload_seen   = 0;
            summaries_seen = 0;
            tagged_seen    = 0;
            short_seen     = 0;
            over_seen      = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            hdr_pos   = '0;
            dest_acc  = '0;
            src_acc   = '0;
            type_word = '0;
            eth_type  = '0;
            tag_flag  = 1'b0;
            vid       = '0;
            pay_count = 0;
            over      = 1'b0;
        endfunction

        function void set_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_MAX_PAYLOAD)
                max_payload = data[MAXP_W-1:0];
            else if (idx == REG_VLAN_TAG_TYPE)
                tag_type = data[TAGT_W-1:0];
        endfunction

        function logic [POS_W-1:0] header_len();
            return tag_flag ? TAGGED_HEADER : PLAIN_HEADER;
        endfunction

        function void note_byte(logic [7:0] b, logic eof);
            res_t        r;
            int unsigned count_top;
            count_top  = (1 << LENGTH_BITS_DEFAULT) - 1;
            bytes_seen = bytes_seen + 1;
            if (hdr_pos < header_len())
            begin
                if (hdr_pos < DEST_END)
                    dest_acc = {dest_acc[39:0], b};
                else if (hdr_pos < SRC_END)
                    src_acc = {src_acc[39:0], b};
                else if (hdr_pos < PLAIN_HEADER)
                begin
                    type_word = {type_word[7:0], b};
                    if (hdr_pos == TYPE_LAST)
                        tag_flag = (type_word == tag_type);
                end
                else if (hdr_pos < TAG_END)
                    vid = {vid[3:0], b};
                else
                    eth_type = {eth_type[7:0], b};
                hdr_pos = hdr_pos + POS_W'(1);
            end
            else
            begin
                if (pay_count >= max_payload)
                    over = 1'b1;
                else
                begin
                    r = '0;
                    r.kind = KIND_PAYLOAD;
                    r.payload_byte = b;
                    r.last = !eof;
                    pending_results.push_back(r);
                end
                if (pay_count < count_top)
                    pay_count = pay_count + 1;
            end
            if (eof)
            begin
                r = '0;
                r.kind = KIND_SUMMARY;
                r.last = 1'b1;
                if (hdr_pos >= header_len())
                begin
                    r.dest_addr      = dest_acc;
                    r.source_addr    = src_acc;
                    r.tagged_res     = tag_flag;
                    r.vlan_number    = tag_flag ? vid : 12'd0;
                    r.type_field     = tag_flag ? eth_type : type_word;
                    r.payload_length = pay_count[LEN_W-1:0];
                    r.status         = over ? ST_OVER : ST_OK;
                end
                else
                    r.status = ST_SHORT;
                pending_results.push_back(r);
                clear_frame();
            end
        endfunction

        function void compare(string field, logic [47:0] want_v, logic [47:0] got_v);
            if (want_v !== got_v)
            begin
                $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want_v,
                         got_v);
                errors = errors + 1;
            end
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual %h", $time, got);
                errors = errors + 1;
                return;
            end
            want = pending_results.pop_front();
            compare("kind", want.kind, got.kind);
            compare("payload_byte", want.payload_byte, got.payload_byte);
            compare("dest_addr", want.dest_addr, got.dest_addr);
            compare("source_addr", want.source_addr, got.source_addr);
            compare("tagged_res", want.tagged_res, got.tagged_res);
            compare("vlan_number", want.vlan_number, got.vlan_number);
            compare("type_field", want.type_field, got.type_field);
            compare("payload_length", want.payload_length, got.payload_length);
            compare("status", want.status, got.status);
            compare("last", want.last, got.last);
            if (want.kind == KIND_SUMMARY)
            begin
                summaries_seen = summaries_seen + 1;
                if (want.tagged_res)
                    tagged_seen = tagged_seen + 1;
                if (want.status == ST_SHORT)
                    short_seen = short_seen + 1;
                if (want.status == ST_OVER)
                    over_seen = over_seen + 1;
            end
            else
                payload_seen = payload_seen + 1;
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    evfp_in_if  frame_bytes();
    evfp_out_if parse_results();

    ethernet_vlan_frame_parser_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .bytes     (frame_bytes),
        .results   (parse_results),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    frame_scoreboard sb = new();
    logic [7:0]      frame_q[$];
    int              tx_idle_pct;
    int              rx_idle_pct;
    int              cycles = 0;
    res_t            seen;

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_ethernet_vlan_frame_parser_top: FAIL");
            $finish;
        end
    end

    always @(posedge clk)
        parse_results.ready <= rst_n && ($urandom_range(0, 99) >= rx_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (frame_bytes.valid && frame_bytes.ready)
                sb.note_byte(frame_bytes.byte_value, frame_bytes.end_of_frame);
            if (parse_results.valid && parse_results.ready)
            begin
                seen.kind           = parse_results.kind;
                seen.payload_byte   = parse_results.payload_byte;
                seen.dest_addr      = parse_results.dest_addr;
                seen.source_addr    = parse_results.source_addr;
                seen.tagged_res     = parse_results.tagged_res;
                seen.vlan_number    = parse_results.vlan_number;
                seen.type_field     = parse_results.type_field;
                seen.payload_length = parse_results.payload_length;
                seen.status         = status_t'(parse_results.status);
                seen.last           = parse_results.last;
                sb.check_result(seen);
            end
        end
    end

    task automatic configure(input logic [MAXP_W-1:0] mp, input logic [TAGT_W-1:0] tt);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MAX_PAYLOAD;
        cfg_data  <= CFG_DATA_W'(mp);
        @(posedge clk);
        sb.set_config(REG_MAX_PAYLOAD, CFG_DATA_W'(mp));
        cfg_index <= REG_VLAN_TAG_TYPE;
        cfg_data  <= tt;
        @(posedge clk);
        sb.set_config(REG_VLAN_TAG_TYPE, tt);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eof);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            frame_bytes.valid <= 1'b0;
            @(posedge clk);
        end
        frame_bytes.valid        <= 1'b1;
        frame_bytes.byte_value   <= b;
        frame_bytes.end_of_frame <= eof;
        @(posedge clk);
        while (!frame_bytes.ready)
            @(posedge clk);
    endtask

    task automatic send_frame();
        int i;
        for (i = 0; i < frame_q.size(); i++)
            send_byte(frame_q[i], i == frame_q.size() - 1);
        frame_q.delete();
    endtask

    task automatic push_run(input logic [7:0] v, input int n);
        repeat (n) frame_q.push_back(v);
    endtask

    task automatic drain();
        frame_bytes.valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic make_frame();
        logic [15:0] tw;
        int          n_pay;
        int          keep;
        repeat (12) frame_q.push_back(8'($urandom_range(0, 255)));
        tw = $urandom_range(0, 1) ? sb.tag_type : 16'($urandom_range(0, 65535));
        frame_q.push_back(tw[15:8]);
        frame_q.push_back(tw[7:0]);
        if (tw == sb.tag_type)
            repeat (4) frame_q.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 7) == 0 && sb.max_payload <= 60)
            n_pay = sb.max_payload + $urandom_range(0, 3);
        else
            n_pay = $urandom_range(0, 24);
        repeat (n_pay) frame_q.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 7) == 0)
        begin
            keep = $urandom_range(1, 17);
            while (frame_q.size() > keep)
                void'(frame_q.pop_back());
        end
    endtask

    initial
    begin
        int mode;
        int seg;
        int seg_bytes;
        logic [MAXP_W-1:0] mp;
        logic [TAGT_W-1:0] tt;

        rst_n                      = 1'b0;
        cfg_we                     = 1'b0;
        cfg_index                  = '0;
        cfg_data                   = '0;
        frame_bytes.valid          = 1'b0;
        frame_bytes.byte_value     = '0;
        frame_bytes.end_of_frame   = 1'b0;
        tx_idle_pct                = 23;
        rx_idle_pct                = 79;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-byte frame, then a tagged header that ends exactly at byte 17
        push_run(8'hFF, 1);
        send_frame();
        push_run(8'hFF, 6);
        push_run(8'h00, 6);
        push_run(8'h81, 1);
        push_run(8'h00, 1);
        push_run(8'hFF, 4);
        send_frame();
        push_run(8'h00, 6);
        push_run(8'hFF, 6);
        push_run(8'h08, 1);
        push_run(8'h00, 2);
        push_run(8'hFF, 1);
        push_run(8'hA5, 1);
        send_frame();
        // tagged frame cut after the tag, before the inner type field
        push_run(8'hA5, 6);
        push_run(8'h5A, 6);
        push_run(8'h81, 1);
        push_run(8'h00, 1);
        push_run(8'h12, 1);
        push_run(8'h34, 1);
        send_frame();
        drain();

        // new tag type: the old one no longer tags, payload limit zero drops all
        configure('0, 16'h88A8);
        push_run(8'h01, 12);
        push_run(8'h81, 1);
        push_run(8'h00, 1);
        push_run(8'h7E, 1);
        push_run(8'hFF, 1);
        send_frame();
        push_run(8'h02, 12);
        push_run(8'h88, 1);
        push_run(8'hA8, 1);
        push_run(8'h0F, 1);
        push_run(8'hFF, 1);
        push_run(8'h86, 1);
        push_run(8'hDD, 1);
        push_run(8'h11, 1);
        send_frame();
        drain();

        for (mode = 0; mode < 3; mode++)
        begin
            tx_idle_pct = (mode == 0) ? 23 : (mode == 1) ? 79 : 0;
            rx_idle_pct = (mode == 0) ? 79 : (mode == 1) ? 23 : 0;
            for (seg = 0; seg < 3; seg++)
            begin
                case ((mode * 3 + seg) % 3)
                    0: mp = MAXP_W'($urandom_range(1, 40));
                    1: mp = '0;
                    default: mp = '1;
                endcase
                case ((mode * 3 + seg) % 4)
                    0: tt = VLAN_TAG_TYPE_RESET;
                    1: tt = 16'hFFFF;
                    2: tt = 16'h0000;
                    default: tt = TAGT_W'($urandom_range(0, 65535));
                endcase
                configure(mp, tt);
                seg_bytes = 0;
                while (seg_bytes < SEG_BYTES)
                begin
                    make_frame();
                    seg_bytes = seg_bytes + frame_q.size();
                    send_frame();
                end
                drain();
            end
        end

        // long frame at the largest limit passes every payload byte
        configure('1, VLAN_TAG_TYPE_RESET);
        push_run(8'h3C, 12);
        push_run(8'h08, 1);
        push_run(8'h00, 1);
        repeat (TOP_FRAME_PAYLOAD) frame_q.push_back(8'($urandom_range(0, 255)));
        send_frame();
        drain();

        $display("Covered %0d frame bytes: %0d payload results, %0d frame summaries",
                 sb.bytes_seen, sb.payload_seen, sb.summaries_seen);
        $display("Summaries: %0d tagged, %0d too short, %0d over limit; %0d mismatches",
                 sb.tagged_seen, sb.short_seen, sb.over_seen, sb.errors);
        if (sb.errors == 0)
            $display("tb_ethernet_vlan_frame_parser_top: PASS");
        else
            $display("tb_ethernet_vlan_frame_parser_top: FAIL");
        $finish;
    end
endmodule
